// ----- sv/asv_pkg.sv -----
// asv_pkg: shared types, codes and fixed-point constants of the voice.
// Used by asv_term_unit and additive_synth_voice; depends on nothing.
`default_nettype none
package asv_pkg;

  localparam int unsigned SAMPLE_RATE_DEF = 48000;
  localparam int unsigned SINE_DEPTH_DEF  = 1024;
  localparam int unsigned MAX_HARM_DEF    = 64;

  localparam int unsigned DIV_W    = 18;

  localparam logic [1:0] OP_START     = 2'd0;
  localparam logic [1:0] OP_STOP_TAIL = 2'd1;
  localparam logic [1:0] OP_STOP_NOW  = 2'd2;
  localparam logic [1:0] OP_TICK      = 2'd3;

  localparam logic [1:0] WAVE_SINE   = 2'd0;
  localparam logic [1:0] WAVE_SQUARE = 2'd1;
  localparam logic [1:0] WAVE_TRI    = 2'd2;
  localparam logic [1:0] WAVE_SAW    = 2'd3;

  localparam logic [1:0] CFG_WAVEFORM  = 2'd0;
  localparam logic [1:0] CFG_HARMONICS = 2'd1;

  localparam logic [6:0]  HARM_RESET = 7'd50;
  localparam logic [13:0] LEVEL_MUL  = 14'd9830;
  localparam logic [16:0] TAIL_ONE   = 17'd32768;
  localparam logic [15:0] TAIL_DECAY = 16'd32440;
  localparam logic [15:0] TAIL_FLOOR = 16'd163;
  localparam logic signed [17:0] TRI_SCALE = 18'sd53121;
  localparam logic signed [17:0] SAW_SCALE = 18'sd20861;
  localparam longint signed SAMPLE_MAX = 64'sd131071;
  localparam longint signed SAMPLE_MIN = -64'sd131072;

  localparam logic [63:0] FREQ_UNIT = 64'd10000000;
  localparam logic [63:0] OCTAVE_FREQ [12] = '{
    64'd81757989, 64'd86619572, 64'd91770240, 64'd97227182,
    64'd103008612, 64'd109133822, 64'd115623257, 64'd122498574,
    64'd129782718, 64'd137500000, 64'd145676175, 64'd154338532
  };

  typedef struct packed {
    logic       clear;
    logic       valid;
    logic       negate;
    logic [1:0] wave;
  } term_cmd_t;

  function automatic logic signed [63:0] round_shift(input logic signed [63:0] v,
                                                     input int unsigned s);
    logic [63:0] mag;
    logic [63:0] r;
    mag = (v < 0) ? 64'(-v) : 64'(v);
    r = (mag + (64'd1 << (s - 1))) >> s;
    return (v < 0) ? -$signed(r) : $signed(r);
  endfunction

endpackage
`default_nettype wire

// ----- sv/asv_sine_rom.sv -----
// asv_sine_rom: sine table with registered read, built at elaboration.
// Depends on nothing but its depth parameter.
`default_nettype none
module asv_sine_rom #(
  parameter int unsigned SINE_TABLE_DEPTH = 1024,
  localparam int unsigned AW = $clog2(SINE_TABLE_DEPTH)
) (
  input  wire logic                 clk,
  input  wire logic [AW-1:0]        addr,
  output logic signed [15:0]        data
);

  localparam logic [63:0] Q30_ONE     = 64'd1073741824;
  localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

  typedef logic signed [15:0] rom_t [SINE_TABLE_DEPTH];

  function automatic rom_t build_rom();
    rom_t t;
    logic [63:0] tt, quad, r, x, x2, a, v;
    for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
      tt = (64'(i) << 32) / 64'(SINE_TABLE_DEPTH);
      quad = (tt >> 30) & 64'd3;
      r = tt & (Q30_ONE - 64'd1);
      if (quad[0]) r = Q30_ONE - r;
      x = (r * PI_HALF_Q30 + (Q30_ONE >> 1)) >> 30;
      x2 = (x * x + (Q30_ONE >> 1)) >> 30;
      a = Q30_ONE - x2 / 64'd110;
      a = Q30_ONE - ((x2 * a) >> 30) / 64'd72;
      a = Q30_ONE - ((x2 * a) >> 30) / 64'd42;
      a = Q30_ONE - ((x2 * a) >> 30) / 64'd20;
      a = Q30_ONE - ((x2 * a) >> 30) / 64'd6;
      a = (x * a) >> 30;
      v = (a * 64'd32767 + (Q30_ONE >> 1)) >> 30;
      if (v > 64'd32767) v = 64'd32767;
      t[i] = (quad >= 64'd2) ? -$signed(16'(v)) : $signed(16'(v));
    end
    return t;
  endfunction

  localparam rom_t ROM = build_rom();

  always_ff @(posedge clk) begin
    data <= ROM[addr];
  end

endmodule
`default_nettype wire

// ----- sv/asv_term_unit.sv -----
// asv_term_unit: pipelined harmonic term unit: table lookup, division of the
// scaled sine by the harmonic divisor, and the running sum.
// Depends on asv_pkg and asv_sine_rom.
`default_nettype none
module asv_term_unit #(
  parameter int unsigned SINE_TABLE_DEPTH = asv_pkg::SINE_DEPTH_DEF,
  parameter int unsigned MAX_HARMONICS    = asv_pkg::MAX_HARM_DEF,
  localparam int unsigned JW    = $clog2(MAX_HARMONICS > 1 ? MAX_HARMONICS : 2),
  localparam int unsigned ACC_W = 32 + $clog2(MAX_HARMONICS + 1)
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire asv_pkg::term_cmd_t      cmd,
  input  wire logic [31:0]             cmd_angle,
  input  wire logic [JW-1:0]           cmd_j,
  output logic                         busy,
  output logic signed [ACC_W-1:0]      acc
);

  localparam int unsigned AW = $clog2(SINE_TABLE_DEPTH);
  localparam int unsigned DW = asv_pkg::DIV_W;

  typedef logic [31:0] tab_t [MAX_HARMONICS];

  function automatic logic [31:0] recip(input logic [31:0] d);
    logic [32:0] rem;
    logic [31:0] q;
    rem = '0;
    q = '0;
    for (int i = 31; i >= 0; i--) begin
      rem = {rem[31:0], (i == 31) ? 1'b1 : 1'b0};
      if (rem >= 33'(d)) begin
        rem = rem - 33'(d);
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic tab_t build_div(input logic [1:0] kind);
    tab_t t;
    logic [31:0] m;
    for (int j = 0; j < MAX_HARMONICS; j++) begin
      m = 32'(2 * j + 1);
      case (kind)
        asv_pkg::WAVE_TRI: t[j] = m * m;
        asv_pkg::WAVE_SAW: t[j] = 32'(j + 1);
        default:           t[j] = m;
      endcase
    end
    return t;
  endfunction

  function automatic tab_t build_rcp(input logic [1:0] kind);
    tab_t t;
    t = build_div(kind);
    for (int j = 0; j < MAX_HARMONICS; j++) t[j] = recip(t[j]);
    return t;
  endfunction

  localparam tab_t DIV_ODD = build_div(asv_pkg::WAVE_SQUARE);
  localparam tab_t DIV_SQ  = build_div(asv_pkg::WAVE_TRI);
  localparam tab_t DIV_SAW = build_div(asv_pkg::WAVE_SAW);
  localparam tab_t RCP_ODD = build_rcp(asv_pkg::WAVE_SQUARE);
  localparam tab_t RCP_SQ  = build_rcp(asv_pkg::WAVE_TRI);
  localparam tab_t RCP_SAW = build_rcp(asv_pkg::WAVE_SAW);

  logic          a_valid, b_valid, c_valid, d_valid, e_valid;
  logic [AW-1:0] a_idx;
  logic [JW-1:0] a_j;
  logic          a_neg, b_neg;
  logic [1:0]    a_wave;
  logic [31:0]   b_rcp;
  logic [DW-1:0] b_d, c_d, d_d;
  logic signed [15:0] rom_data;
  logic [29:0]   c_n;
  logic [30:0]   c_qe, d_qe;
  logic          c_neg, d_neg;
  logic [DW:0]   d_r;
  logic signed [ACC_W-1:0] e_term;

  logic [63:0]   idx_prod;
  logic [15:0]   rom_mag;
  logic [29:0]   n_val;
  logic [61:0]   qe_prod;
  logic [48:0]   qd_prod;
  logic [30:0]   r_full;
  logic [30:0]   q_fix;

  asv_sine_rom #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_rom (
    .clk  (clk),
    .addr (a_idx),
    .data (rom_data)
  );

  always_comb begin
    idx_prod = 64'(cmd_angle) * 64'(SINE_TABLE_DEPTH);
    rom_mag  = (rom_data < 0) ? 16'(-rom_data) : 16'(rom_data);
    n_val    = {rom_mag[14:0], 15'd0};
    qe_prod  = 62'(n_val) * 62'(b_rcp);
    qd_prod  = 49'(c_qe) * 49'(c_d);
    r_full   = 31'(c_n) - qd_prod[30:0];
    q_fix    = d_qe + ((32'(d_r) >= 32'(d_d)) ? 31'd1 : 31'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
      d_valid <= 1'b0;
      e_valid <= 1'b0;
    end else begin
      a_valid <= cmd.valid;
      b_valid <= a_valid;
      c_valid <= b_valid;
      d_valid <= c_valid;
      e_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    a_idx  <= idx_prod[32 +: AW];
    a_j    <= cmd_j;
    a_neg  <= cmd.negate;
    a_wave <= cmd.wave;

    b_neg <= a_neg;
    case (a_wave)
      asv_pkg::WAVE_TRI: begin
        b_rcp <= RCP_SQ[a_j];
        b_d   <= DIV_SQ[a_j][DW-1:0];
      end
      asv_pkg::WAVE_SAW: begin
        b_rcp <= RCP_SAW[a_j];
        b_d   <= DIV_SAW[a_j][DW-1:0];
      end
      default: begin
        b_rcp <= RCP_ODD[a_j];
        b_d   <= DIV_ODD[a_j][DW-1:0];
      end
    endcase

    c_n   <= n_val;
    c_qe  <= qe_prod[61:31];
    c_d   <= b_d;
    c_neg <= b_neg ^ (rom_data < 0);

    d_r   <= r_full[DW:0];
    d_qe  <= c_qe;
    d_d   <= c_d;
    d_neg <= c_neg;

    e_term <= d_neg ? -$signed(ACC_W'(q_fix)) : $signed(ACC_W'(q_fix));
  end

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      acc <= '0;
    end else if (e_valid) begin
      acc <= acc + e_term;
    end
  end

  assign busy = a_valid | b_valid | c_valid | d_valid | e_valid;

endmodule
`default_nettype wire

// ----- sv/additive_synth_voice.sv -----
// additive_synth_voice: one additive synthesizer voice, top level with the
// item sequencer, the voice state and the shared post-scaling multiplier.
// Depends on asv_pkg and asv_term_unit.
//
// Items arrive on the item channel (item_valid / item_stall): an operation
// with note_number and velocity. Each item yields exactly one beat on the
// result channel (result_valid / result_stall) with sample and sounding.
// Configuration (waveform, harmonic count) is written over the cfg channel,
// which is always ready; write only while the voice is idle.
// Start and stop items go straight to the result. A tick on a sounding voice
// issues n harmonic terms (1 for sine, min(K, MAX_HARMONICS) for square and
// triangle, one less for sawtooth), drains the term unit, scales the sum for
// triangle and sawtooth, and applies level and gain; with no terms it goes
// straight to the drain. The term unit accepts one harmonic per cycle, then drains.
// Item stall stays high while an item is in progress. A finished result
// waits in the output register; the next item is taken meanwhile but its
// result waits until that register is free. Reset clears the voice to
// silent, waveform to sine and the harmonic count to 50.
`default_nettype none
module additive_synth_voice #(
  parameter int unsigned SAMPLE_RATE      = asv_pkg::SAMPLE_RATE_DEF,
  parameter int unsigned SINE_TABLE_DEPTH = asv_pkg::SINE_DEPTH_DEF,
  parameter int unsigned MAX_HARMONICS    = asv_pkg::MAX_HARM_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               item_valid,
  output logic                    item_stall,
  input  wire logic [1:0]         operation,
  input  wire logic [6:0]         note_number,
  input  wire logic [7:0]         velocity,
  output logic                    result_valid,
  input  wire logic               result_stall,
  output logic signed [17:0]      sample,
  output logic                    sounding,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [6:0]         cfg_data
);

  localparam int unsigned JW     = $clog2(MAX_HARMONICS > 1 ? MAX_HARMONICS : 2);
  localparam int unsigned KW     = $clog2(MAX_HARMONICS + 1);
  localparam int unsigned ACC_W  = 32 + $clog2(MAX_HARMONICS + 1);
  localparam int unsigned PROD_W = ACC_W + 18;

  typedef logic [31:0] step_tab_t [128];

  function automatic step_tab_t build_steps();
    step_tab_t t;
    logic [63:0] s0, st;
    int unsigned oct;
    for (int n = 0; n < 128; n++) begin
      oct = n / 12;
      s0 = (asv_pkg::OCTAVE_FREQ[n % 12] << 32) / 64'(SAMPLE_RATE);
      st = ((s0 << oct) + asv_pkg::FREQ_UNIT / 64'd2) / asv_pkg::FREQ_UNIT;
      t[n] = (st[31:0] == 32'd0) ? 32'd1 : st[31:0];
    end
    return t;
  endfunction

  localparam step_tab_t NOTE_STEP = build_steps();

  typedef enum logic [9:0] {
    S_IDLE      = 10'b0000000001,
    S_ISSUE     = 10'b0000000010,
    S_DRAIN     = 10'b0000000100,
    S_SCALE_MUL = 10'b0000001000,
    S_SCALE_RND = 10'b0000010000,
    S_LEVEL_MUL = 10'b0000100000,
    S_LEVEL_RND = 10'b0001000000,
    S_GAIN_MUL  = 10'b0010000000,
    S_GAIN_RND  = 10'b0100000000,
    S_FINISH    = 10'b1000000000
  } state_t;

  state_t state;

  logic [1:0]  waveform;
  logic [6:0]  harmonic_count;
  logic [31:0] phase;
  logic [31:0] phase_step;
  logic [15:0] note_level;
  logic [15:0] tail_gain;

  logic [31:0]   angle;
  logic [31:0]   angle_inc;
  logic [JW-1:0] term_j;
  logic [KW-1:0] terms_left;

  logic signed [ACC_W-1:0]  post_v;
  logic signed [PROD_W-1:0] prod;
  logic signed [17:0]       sample_hold;

  asv_pkg::term_cmd_t       cmd;
  logic                     unit_busy;
  logic signed [ACC_W-1:0]  unit_acc;

  logic                     accept;
  logic [KW-1:0]            k_eff;
  logic [KW-1:0]            n_terms;
  logic [23:0]              lvl_prod;
  logic [31:0]              tail_prod;
  logic [15:0]              tail_dec;
  logic [16:0]              gain;
  logic signed [ACC_W-1:0]  mul_a;
  logic signed [17:0]       mul_b;
  logic signed [63:0]       rnd16;
  logic signed [63:0]       rnd28;
  logic signed [17:0]       sat_v;
  logic                     out_free;

  asv_term_unit #(
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
    .MAX_HARMONICS    (MAX_HARMONICS)
  ) u_term (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cmd_angle (angle),
    .cmd_j     (term_j),
    .busy      (unit_busy),
    .acc       (unit_acc)
  );

  assign cfg_ready  = 1'b1;
  assign item_stall = (state != S_IDLE);
  assign accept     = item_valid & ~item_stall;
  assign out_free   = ~result_valid | ~result_stall;

  always_comb begin
    if (32'(harmonic_count) > MAX_HARMONICS) k_eff = KW'(MAX_HARMONICS);
    else k_eff = KW'(harmonic_count);
    case (waveform)
      asv_pkg::WAVE_SINE: n_terms = KW'(1);
      asv_pkg::WAVE_SAW:  n_terms = (k_eff == '0) ? '0 : k_eff - KW'(1);
      default:            n_terms = k_eff;
    endcase

    lvl_prod  = 24'(velocity) * 24'(asv_pkg::LEVEL_MUL) + 24'd128;
    tail_prod = 32'(tail_gain) * 32'(asv_pkg::TAIL_DECAY) + 32'd16384;
    tail_dec  = tail_prod[30:15];
    gain      = (tail_gain != 16'd0) ? {1'b0, tail_gain} : asv_pkg::TAIL_ONE;

    cmd.clear  = accept & (operation == asv_pkg::OP_TICK);
    cmd.valid  = (state == S_ISSUE);
    cmd.negate = (waveform == asv_pkg::WAVE_TRI) & term_j[0];
    cmd.wave   = waveform;

    case (state)
      S_SCALE_MUL: begin
        mul_a = unit_acc;
        mul_b = (waveform == asv_pkg::WAVE_TRI) ? asv_pkg::TRI_SCALE : asv_pkg::SAW_SCALE;
      end
      S_LEVEL_MUL: begin
        mul_a = post_v;
        mul_b = $signed({2'b00, note_level});
      end
      default: begin
        mul_a = post_v;
        mul_b = $signed({1'b0, gain});
      end
    endcase

    rnd16 = asv_pkg::round_shift(64'(prod), 16);
    rnd28 = asv_pkg::round_shift(64'(prod), 28);
    if (rnd28 > asv_pkg::SAMPLE_MAX) sat_v = 18'(asv_pkg::SAMPLE_MAX);
    else if (rnd28 < asv_pkg::SAMPLE_MIN) sat_v = 18'(asv_pkg::SAMPLE_MIN);
    else sat_v = 18'(rnd28);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      waveform       <= asv_pkg::WAVE_SINE;
      harmonic_count <= asv_pkg::HARM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        asv_pkg::CFG_WAVEFORM:  waveform <= cfg_data[1:0];
        asv_pkg::CFG_HARMONICS: harmonic_count <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_SCALE_MUL || state == S_LEVEL_MUL || state == S_GAIN_MUL) begin
      prod <= PROD_W'(mul_a * mul_b);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      phase        <= '0;
      phase_step   <= '0;
      note_level   <= '0;
      tail_gain    <= '0;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && !result_stall && state != S_FINISH) result_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            sample_hold <= '0;
            angle       <= phase;
            angle_inc   <= (waveform == asv_pkg::WAVE_SAW) ? phase : {phase[30:0], 1'b0};
            term_j      <= '0;
            terms_left  <= n_terms;
            state       <= S_FINISH;
            case (operation)
              asv_pkg::OP_START: begin
                phase      <= '0;
                note_level <= lvl_prod[23:8];
                tail_gain  <= '0;
                phase_step <= NOTE_STEP[note_number];
              end
              asv_pkg::OP_STOP_TAIL: begin
                if (tail_gain == 16'd0) tail_gain <= asv_pkg::TAIL_ONE[15:0];
              end
              asv_pkg::OP_STOP_NOW: begin
                phase_step <= '0;
                tail_gain  <= '0;
              end
              default: begin
                if (phase_step != 32'd0) begin
                  state <= (n_terms == '0) ? S_DRAIN : S_ISSUE;
                end
              end
            endcase
          end
        end
        S_ISSUE: begin
          angle      <= angle + angle_inc;
          term_j     <= term_j + JW'(1);
          terms_left <= terms_left - KW'(1);
          if (terms_left == KW'(1)) state <= S_DRAIN;
        end
        S_DRAIN: begin
          if (!unit_busy) begin
            post_v <= unit_acc;
            if (waveform == asv_pkg::WAVE_TRI || waveform == asv_pkg::WAVE_SAW) begin
              state <= S_SCALE_MUL;
            end else begin
              state <= S_LEVEL_MUL;
            end
          end
        end
        S_SCALE_MUL: state <= S_SCALE_RND;
        S_SCALE_RND: begin
          post_v <= (waveform == asv_pkg::WAVE_SAW) ? -ACC_W'(rnd16) : ACC_W'(rnd16);
          state  <= S_LEVEL_MUL;
        end
        S_LEVEL_MUL: state <= S_LEVEL_RND;
        S_LEVEL_RND: begin
          post_v <= ACC_W'(rnd16);
          state  <= S_GAIN_MUL;
        end
        S_GAIN_MUL: state <= S_GAIN_RND;
        S_GAIN_RND: begin
          sample_hold <= sat_v;
          phase       <= phase + phase_step;
          if (tail_gain != 16'd0) begin
            if (tail_dec <= asv_pkg::TAIL_FLOOR) begin
              tail_gain  <= '0;
              phase_step <= '0;
            end else begin
              tail_gain <= tail_dec;
            end
          end
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (out_free) begin
            result_valid <= 1'b1;
            sample       <= sample_hold;
            sounding     <= (phase_step != 32'd0);
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire
